FILE: src/mfdr_pkg.sv
// Shared types and constants for the mixed fraction divide and reduce unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mfdr_pkg;

  // Internal arithmetic runs modulo 2^64; results keep the low 48 bits.
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned SHIFT_W = $clog2(WORD_W) + 1;

  typedef logic [WORD_W-1:0] word_t;

  // Magnitude of a two's complement word, as an unsigned word.
  function automatic word_t mag_of(input word_t v);
    return v[WORD_W-1] ? (word_t'(0) - v) : v;
  endfunction

endpackage

FILE: src/mfdr_mul.sv
// Sequential shift-add multiplier: product = addend + mcand * mplier (mod 2^64).
// The multiplier is a signed IN_BITS value, one bit per cycle. Uses mfdr_pkg.
`timescale 1ns / 1ps

module mfdr_mul import mfdr_pkg::*; #(
  parameter int unsigned IN_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  word_t              mcand_i,
  input  logic [IN_BITS-1:0] mplier_i,
  input  word_t              addend_i,
  output logic               done_o,
  output word_t              prod_o
);

  localparam int unsigned CNT_W = $clog2(IN_BITS);

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  word_t              mc_q, mc_d;
  logic [IN_BITS-1:0] mp_q, mp_d;
  word_t              acc_q, acc_d;
  logic               done_q, done_d;
  word_t              term;
  logic               last;

  // One partial product per cycle; the top bit of the multiplier has negative weight.
  assign term = mp_q[0] ? mc_q : '0;
  assign last = (cnt_q == CNT_W'(IN_BITS - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mc_d    = mc_q;
    mp_d    = mp_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mc_d    = mcand_i;
          mp_d    = mplier_i;
          acc_d   = addend_i;
          cnt_d   = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        acc_d = last ? (acc_q - term) : (acc_q + term);
        mc_d  = mc_q << 1;
        mp_d  = mp_q >> 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (last) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q  <= mc_d;
    mp_q  <= mp_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: src/mfdr_gcd.sv
// Binary gcd of two unsigned 64-bit values, one shift or subtract step per cycle.
// A zero operand yields the other one; both zero yields zero. Uses mfdr_pkg.
`timescale 1ns / 1ps

module mfdr_gcd import mfdr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t u_i,
  input  word_t v_i,
  output logic  done_o,
  output word_t gcd_o
);

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e             state_q, state_d;
  word_t              u_q, u_d;
  word_t              v_q, v_d;
  logic [SHIFT_W-1:0] k_q, k_d;
  word_t              res_q, res_d;
  logic               done_q, done_d;
  logic [WORD_W:0]    u_minus_v;
  word_t              v_minus_u;

  assign u_minus_v = {1'b0, u_q} - {1'b0, v_q};
  assign v_minus_u = v_q - u_q;

  always_comb begin
    state_d = state_q;
    u_d     = u_q;
    v_d     = v_q;
    k_d     = k_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          u_d     = u_i;
          v_d     = v_i;
          k_d     = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (u_q == '0) begin
          // Finished: restore the common power of two.
          res_d   = v_q << k_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (v_q == '0) begin
          res_d   = u_q << k_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + SHIFT_W'(1);
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (!u_minus_v[WORD_W]) begin
          // Both odd: the difference is even, so halve it at once.
          u_d = u_minus_v[WORD_W-1:0] >> 1;
        end else begin
          v_d = v_minus_u >> 1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    v_q   <= v_d;
    k_q   <= k_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign gcd_o  = res_q;

endmodule

FILE: src/mfdr_div.sv
// Restoring divider for unsigned 64-bit values, one quotient bit per cycle.
// The divisor is never zero when started. Uses mfdr_pkg.
`timescale 1ns / 1ps

module mfdr_div import mfdr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t dividend_i,
  input  word_t divisor_i,
  output logic  done_o,
  output word_t quot_o
);

  localparam int unsigned CNT_W = $clog2(WORD_W);

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  word_t            rem_q, rem_d;
  word_t            quo_q, quo_d;
  word_t            dsr_q, dsr_d;
  logic             done_q, done_d;
  logic [WORD_W:0]  trial;
  logic             ge;

  // Shift the next dividend bit into the remainder and try a subtraction.
  assign trial = {rem_q, quo_q[WORD_W-1]};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rem_d   = '0;
          quo_d   = dividend_i;
          dsr_d   = divisor_i;
          cnt_d   = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        rem_d = ge ? WORD_W'(trial - {1'b0, dsr_q}) : trial[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WORD_W - 1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: src/mixed_fraction_divide_reduce_unit.sv
// Top level: divides two signed mixed numbers and reduces the quotient by its gcd.
// Sequences mfdr_mul, mfdr_gcd and mfdr_div; uses mfdr_pkg.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ---------------------------------------------
//   request   start_i, busy_o      a_whole_i a_num_i a_den_i b_whole_i b_num_i b_den_i
//   result    done_o (one cycle)   quot_num_o quot_den_o zero_divisor_o
//
// A request is taken when start_i is high and busy_o is low; busy_o stays high
// until the result strobe. A request runs four multiplies, one multiplier bit
// per cycle, then the binary gcd, then two divisions, one quotient bit per cycle.
// When both quotient parts are zero the divisions are skipped.
// Reset clears all control state; the receiver cannot stall, and the results
// are held only until the next request overwrites them.
`timescale 1ns / 1ps

module mixed_fraction_divide_reduce_unit import mfdr_pkg::*; #(
  parameter int unsigned IN_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [IN_BITS-1:0] a_whole_i,
  input  logic signed [IN_BITS-1:0] a_num_i,
  input  logic signed [IN_BITS-1:0] a_den_i,
  input  logic signed [IN_BITS-1:0] b_whole_i,
  input  logic signed [IN_BITS-1:0] b_num_i,
  input  logic signed [IN_BITS-1:0] b_den_i,
  output logic                     done_o,
  output logic signed [OUT_W-1:0]  quot_num_o,
  output logic signed [OUT_W-1:0]  quot_den_o,
  output logic                     zero_divisor_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_A, S_MUL_B, S_MUL_N, S_MUL_D, S_GCD, S_DIV_N, S_DIV_D
  } state_e;

  state_e             state_q, state_d;
  logic [IN_BITS-1:0] aw_q, an_q, ad_q, bw_q, bn_q, bd_q;
  word_t              a_impr_q, a_impr_d;
  word_t              b_impr_q, b_impr_d;
  word_t              num_q, num_d;
  word_t              den_q, den_d;
  word_t              g_q, g_d;
  logic [OUT_W-1:0]   rn_q, rn_d;
  logic [OUT_W-1:0]   rd_q, rd_d;
  logic               zd_q, zd_d;
  logic               done_q, done_d;
  logic               mul_start_q, mul_start_d;
  logic               gcd_start_q, gcd_start_d;
  logic               div_start_q, div_start_d;
  logic               accept;

  word_t              mul_mcand, mul_addend, mul_prod;
  logic [IN_BITS-1:0] mul_mplier;
  logic               mul_done;
  word_t              gcd_val;
  logic               gcd_done;
  word_t              div_dividend, div_quot, quot_signed;
  logic               div_done;

  // Sign extension of a stored input field to the internal word.
  function automatic word_t sext(input logic [IN_BITS-1:0] x);
    return {{(WORD_W - IN_BITS){x[IN_BITS-1]}}, x};
  endfunction

  assign accept = start_i && (state_q == S_IDLE);

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      aw_q <= a_whole_i;
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bw_q <= b_whole_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_mcand  = sext(aw_q);
    mul_mplier = ad_q;
    mul_addend = sext(an_q);
    case (state_q)
      S_MUL_B: begin
        mul_mcand  = sext(bw_q);
        mul_mplier = bd_q;
        mul_addend = sext(bn_q);
      end
      S_MUL_N: begin
        mul_mcand  = a_impr_q;
        mul_mplier = bd_q;
        mul_addend = '0;
      end
      S_MUL_D: begin
        mul_mcand  = b_impr_q;
        mul_mplier = ad_q;
        mul_addend = '0;
      end
      default: ;
    endcase
  end

  // The divider takes the numerator magnitude first, then the denominator.
  assign div_dividend = (state_q == S_DIV_D) ? mag_of(den_q) : mag_of(num_q);
  assign quot_signed  = ((state_q == S_DIV_D) ? den_q[WORD_W-1] : num_q[WORD_W-1])
                        ? (word_t'(0) - div_quot) : div_quot;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    a_impr_d    = a_impr_q;
    b_impr_d    = b_impr_q;
    num_d       = num_q;
    den_d       = den_q;
    g_d         = g_q;
    rn_d        = rn_q;
    rd_d        = rd_q;
    zd_d        = zd_q;
    done_d      = 1'b0;
    mul_start_d = 1'b0;
    gcd_start_d = 1'b0;
    div_start_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d     = S_MUL_A;
          mul_start_d = 1'b1;
        end
      end
      S_MUL_A: begin
        if (mul_done) begin
          a_impr_d    = mul_prod;
          state_d     = S_MUL_B;
          mul_start_d = 1'b1;
        end
      end
      S_MUL_B: begin
        if (mul_done) begin
          b_impr_d    = mul_prod;
          state_d     = S_MUL_N;
          mul_start_d = 1'b1;
        end
      end
      S_MUL_N: begin
        if (mul_done) begin
          num_d       = mul_prod;
          state_d     = S_MUL_D;
          mul_start_d = 1'b1;
        end
      end
      S_MUL_D: begin
        if (mul_done) begin
          den_d       = mul_prod;
          state_d     = S_GCD;
          gcd_start_d = 1'b1;
        end
      end
      S_GCD: begin
        if (gcd_done) begin
          g_d = gcd_val;
          if (gcd_val == '0) begin
            // Both parts zero: numerator and denominator are zero and zero_divisor is set.
            rn_d    = '0;
            rd_d    = '0;
            zd_d    = 1'b1;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d     = S_DIV_N;
            div_start_d = 1'b1;
          end
        end
      end
      S_DIV_N: begin
        if (div_done) begin
          rn_d        = quot_signed[OUT_W-1:0];
          state_d     = S_DIV_D;
          div_start_d = 1'b1;
        end
      end
      S_DIV_D: begin
        if (div_done) begin
          rd_d    = quot_signed[OUT_W-1:0];
          zd_d    = (den_q == '0);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      mul_start_q <= 1'b0;
      gcd_start_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      mul_start_q <= mul_start_d;
      gcd_start_q <= gcd_start_d;
      div_start_q <= div_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_impr_q <= a_impr_d;
    b_impr_q <= b_impr_d;
    num_q    <= num_d;
    den_q    <= den_d;
    g_q      <= g_d;
    rn_q     <= rn_d;
    rd_q     <= rd_d;
    zd_q     <= zd_d;
  end

  mfdr_mul #(
    .IN_BITS (IN_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start_q),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .addend_i (mul_addend),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  mfdr_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start_q),
    .u_i     (mag_of(num_q)),
    .v_i     (mag_of(den_q)),
    .done_o  (gcd_done),
    .gcd_o   (gcd_val)
  );

  mfdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend),
    .divisor_i  (g_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign quot_num_o     = rn_q;
  assign quot_den_o     = rd_q;
  assign zero_divisor_o = zd_q;

endmodule
